// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define HFDR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Checked at every rising clock edge, reset included.
`define HFDR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== hw/rtl/hfdr_pkg.sv =====
package hfdr_pkg;

   // Number of rule cells in the chain.
   localparam int RULE_COUNT = 16;
   localparam int IDX_W      = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
   // Width that holds both a request slot number and any cell number.
   localparam int SLOT_W     = (IDX_W > 4) ? IDX_W : 4;

   localparam logic [1:0] KIND_PACKET = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam int MASK_SRC_IP     = 0;
   localparam int MASK_DST_IP     = 1;
   localparam int MASK_TOS        = 2;
   localparam int MASK_PROTOCOL   = 3;
   localparam int MASK_SRC_MAC    = 4;
   localparam int MASK_ETHER_TYPE = 5;
   localparam int MASK_SRC_PORT   = 6;
   localparam int MASK_DST_PORT   = 7;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  type_of_service;
      logic [7:0]  ip_protocol;
      logic [15:0] ether_type;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } hfdr_hdr_type;

   typedef struct packed {
      logic [1:0]   kind;
      logic [3:0]   rule_index;
      logic [8:0]   enable_mask;
      hfdr_hdr_type hdr;
   } hfdr_word_type;

   // One slot of the chain: the word in flight and the verdict so far.
   typedef struct packed {
      logic          valid;
      hfdr_word_type word;
      logic          decided;
      logic          verdict;
      logic          rule_hit;
      logic [3:0]    hit_index;
   } hfdr_stage_type;

   // True when every field enabled in the mask equals the packet's field.
   function automatic logic fields_match(input logic [8:0] mask,
                                         input hfdr_hdr_type rule,
                                         input hfdr_hdr_type pkt);
      logic ok;
      ok = 1'b1;
      if (mask[MASK_SRC_IP] && rule.src_ip != pkt.src_ip) ok = 1'b0;
      if (mask[MASK_DST_IP] && rule.dst_ip != pkt.dst_ip) ok = 1'b0;
      if (mask[MASK_TOS] && rule.type_of_service != pkt.type_of_service) ok = 1'b0;
      if (mask[MASK_PROTOCOL] && rule.ip_protocol != pkt.ip_protocol) ok = 1'b0;
      if (mask[MASK_SRC_MAC] && rule.src_mac != pkt.src_mac) ok = 1'b0;
      if (mask[MASK_ETHER_TYPE] && rule.ether_type != pkt.ether_type) ok = 1'b0;
      if (mask[MASK_SRC_PORT] && rule.src_port != pkt.src_port) ok = 1'b0;
      if (mask[MASK_DST_PORT] && rule.dst_port != pkt.dst_port) ok = 1'b0;
      return ok;
   endfunction

endpackage

// ===== hw/rtl/hfdr_if.sv =====
interface hfdr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  rule_index;
   logic [8:0]  enable_mask;
   logic [47:0] dest_mac;
   logic [47:0] src_mac;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [7:0]  type_of_service;
   logic [7:0]  ip_protocol;
   logic [15:0] ether_type;
   logic [15:0] src_port;
   logic [15:0] dst_port;

   modport source (output valid, kind, rule_index, enable_mask, dest_mac, src_mac, src_ip,
                   dst_ip, type_of_service, ip_protocol, ether_type, src_port, dst_port,
                   input ready);
   modport sink (input valid, kind, rule_index, enable_mask, dest_mac, src_mac, src_ip,
                 dst_ip, type_of_service, ip_protocol, ether_type, src_port, dst_port,
                 output ready);
endinterface

interface hfdr_rsp_if;
   logic       valid;
   logic       ready;
   logic       verdict;
   logic       rule_hit;
   logic [3:0] hit_index;

   modport source (output valid, verdict, rule_hit, hit_index, input ready);
   modport sink (input valid, verdict, rule_hit, hit_index, output ready);
endinterface

// ===== hw/rtl/hfdr_cell.sv =====
// One rule slot. It holds a rule, updates it from write and clear words
// addressed to it, and judges packets not yet decided by an earlier cell.
module hfdr_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [hfdr_pkg::IDX_W-1:0] cell_id,
   input  hfdr_pkg::hfdr_stage_type   prev_stage,
   output hfdr_pkg::hfdr_stage_type   stage_out
);

   logic                     rule_valid_ff;
   logic [8:0]               rule_mask_ff;
   hfdr_pkg::hfdr_hdr_type   rule_hdr_ff;
   hfdr_pkg::hfdr_stage_type stage_ff;
   hfdr_pkg::hfdr_stage_type stage_in;

   logic id_match;
   logic is_write;
   logic is_clear;
   logic mac_match;

   assign id_match  = (hfdr_pkg::SLOT_W'(prev_stage.word.rule_index) ==
                       hfdr_pkg::SLOT_W'(cell_id));
   assign is_write  = prev_stage.valid && prev_stage.word.kind == hfdr_pkg::KIND_WRITE &&
                      id_match;
   assign is_clear  = prev_stage.valid && prev_stage.word.kind == hfdr_pkg::KIND_CLEAR &&
                      id_match;
   assign mac_match = prev_stage.valid && prev_stage.word.kind == hfdr_pkg::KIND_PACKET &&
                      !prev_stage.decided && rule_valid_ff &&
                      rule_hdr_ff.dest_mac == prev_stage.word.hdr.dest_mac;

   always_comb begin
      stage_in = prev_stage;
      if (mac_match) begin
         stage_in.decided   = 1'b1;
         stage_in.rule_hit  = 1'b1;
         stage_in.hit_index = 4'(cell_id);
         stage_in.verdict   = (rule_mask_ff != 9'd0) &&
            hfdr_pkg::fields_match(rule_mask_ff, rule_hdr_ff, prev_stage.word.hdr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_valid_ff <= 1'b0;
      end else if (advance) begin
         if (is_write) begin
            rule_valid_ff <= 1'b1;
         end else if (is_clear) begin
            rule_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_write) begin
         rule_mask_ff <= prev_stage.word.enable_mask;
         rule_hdr_ff  <= prev_stage.word.hdr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== hw/rtl/header_field_drop_rule_filter.sv =====
// First-match header drop filter.
//
// The req channel carries one word per item: a packet to classify, a rule
// write, or a rule clear, selected by kind. The rsp channel returns exactly
// one word per request word, in order: verdict (1 drop, 0 forward), rule_hit
// and hit_index. Writes and clears answer with verdict 0, rule_hit 0 and the
// slot number they addressed.
//
// Each rule lives in its own cell, and the cells form a chain. A word walks
// one cell per cycle unless the output stalls; the lowest-numbered cell
// with a valid rule whose destination MAC matches decides the packet, later
// cells pass it on. Each cell registers the word, and an output register
// follows the last cell. Since the chain is a pipeline, a new word is
// accepted every cycle unless the output stalls, and a write takes effect
// for every packet accepted after it.
//
// Reset clears all rule valid bits and empties the chain and output register.
// When the receiver stalls with a word waiting in the output register, the
// whole chain holds and req.ready drops until that word is taken.
module header_field_drop_rule_filter (
   input logic         clock,
   input logic         reset,
   hfdr_req_if.sink    req,
   hfdr_rsp_if.source  rsp
);

   localparam int N = hfdr_pkg::RULE_COUNT;

   // chain[k] is the input of cell k; chain[N] leaves the last cell.
   hfdr_pkg::hfdr_stage_type chain [0:N];

   logic       advance;
   logic       rsp_valid_ff;
   logic       rsp_verdict_ff;
   logic       rsp_hit_ff;
   logic [3:0] rsp_index_ff;

   // The chain moves whenever the output register is free or being emptied.
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Build the entering word. Writes and clears carry their slot number as
   // the answer; packets and unused kinds start with an all-zero answer.
   always_comb begin
      chain[0].valid                    = req.valid;
      chain[0].word.kind                = req.kind;
      chain[0].word.rule_index          = req.rule_index;
      chain[0].word.enable_mask         = req.enable_mask;
      chain[0].word.hdr.dest_mac        = req.dest_mac;
      chain[0].word.hdr.src_mac         = req.src_mac;
      chain[0].word.hdr.src_ip          = req.src_ip;
      chain[0].word.hdr.dst_ip          = req.dst_ip;
      chain[0].word.hdr.type_of_service = req.type_of_service;
      chain[0].word.hdr.ip_protocol     = req.ip_protocol;
      chain[0].word.hdr.ether_type      = req.ether_type;
      chain[0].word.hdr.src_port        = req.src_port;
      chain[0].word.hdr.dst_port        = req.dst_port;
      chain[0].decided                  = 1'b0;
      chain[0].verdict                  = 1'b0;
      chain[0].rule_hit                 = 1'b0;
      if (req.kind == hfdr_pkg::KIND_WRITE || req.kind == hfdr_pkg::KIND_CLEAR) begin
         chain[0].hit_index = req.rule_index;
      end else begin
         chain[0].hit_index = 4'd0;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_cell
      hfdr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_id    (hfdr_pkg::IDX_W'(k)),
         .prev_stage (chain[k]),
         .stage_out  (chain[k+1])
      );
   end

   // Output register: parts the chain from the receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_verdict_ff <= chain[N].verdict;
         rsp_hit_ff     <= chain[N].rule_hit;
         rsp_index_ff   <= chain[N].hit_index;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.verdict   = rsp_verdict_ff;
   assign rsp.rule_hit  = rsp_hit_ff;
   assign rsp.hit_index = rsp_index_ff;

endmodule

// ===== hw/rtl/hfdr_checker.sv =====
`include "assert_macros.svh"

// Port-level checks on the filter.
module hfdr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_verdict,
   input logic       rsp_rule_hit,
   input logic [3:0] rsp_hit_index
);

   logic [5:0] rsp_payload;

   assign rsp_payload = {rsp_verdict, rsp_rule_hit, rsp_hit_index};

   // A waiting response stays until taken, with its fields unchanged.
   `HFDR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `HFDR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_payload))

   // A drop is always decided by a matching rule.
   `HFDR_ASSERT(a_drop_has_hit, clock, reset, rsp_valid |-> !rsp_verdict || rsp_rule_hit)

   // A stalled output holds back the input side.
   `HFDR_ASSERT(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready |-> !req_ready)

   // Nothing is offered right after reset.
   `HFDR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind header_field_drop_rule_filter hfdr_checker u_hfdr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_verdict   (rsp.verdict),
   .rsp_rule_hit  (rsp.rule_hit),
   .rsp_hit_index (rsp.hit_index)
);
